/* sv/brlh_pkg.sv */
// Shared types, constants and run arithmetic for the binary run-length histogram.
package brlh_pkg;

    localparam int NUM_BINS      = 72;
    localparam int BINS_PER_DIR  = 18;
    localparam int BINS_PER_VAL  = 9;
    localparam int NUM_DIRS      = 4;
    localparam int RUN_BITS      = 9;
    localparam int LEN_BITS      = 8;
    localparam logic [LEN_BITS-1:0] LEN_CAP = 8'd129;
    localparam int BIN_BITS      = 5;
    localparam int SEL_BITS      = 7;
    localparam int OUT_CNT_BITS  = 21;
    localparam int DIM_BITS      = 11;
    localparam int DIM_EXT_BITS  = 13;
    localparam int CFG_IDX_BITS  = 8;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_COUNT_BITS = 21;
    localparam int DIM_RESET      = 1024;
    localparam int FIFO_DEPTH     = 4;

    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 8'd1;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_PIXEL = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        logic                vld;
        logic [BIN_BITS-1:0] bin;
    } t_run_evt;

    typedef struct packed {
        t_run_evt old_run;
        t_run_evt fin_run;
    } t_dir_evt;

    typedef t_dir_evt [NUM_DIRS-1:0] t_evt_set;

    typedef struct packed {
        logic [RUN_BITS-1:0] run;
        t_dir_evt            evt;
    } t_run_res;

    typedef struct packed {
        logic [SEL_BITS-1:0]     echo;
        logic [OUT_CNT_BITS-1:0] count;
    } t_result;

    // ceil(log2(len)), with every length above 128 in class 8.
    function automatic logic [3:0] len_class(input logic [LEN_BITS-1:0] len);
        logic [3:0] cls;
        cls = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (len > LEN_BITS'(1 << i)) cls = 4'(i + 1);
        end
        return cls;
    endfunction

    function automatic logic [BIN_BITS-1:0] run_bin(input logic [RUN_BITS-1:0] run);
        return BIN_BITS'(run[RUN_BITS-1] ? BINS_PER_VAL : 0)
             + BIN_BITS'(len_class(run[LEN_BITS-1:0]));
    endfunction

    // One step of a run: extend it or close it and open a new one.
    function automatic t_run_res run_step(input logic [RUN_BITS-1:0] prev,
                                          input logic has_prev,
                                          input logic v,
                                          input logic ends);
        t_run_res res;
        res = '0;
        if (has_prev && (prev[RUN_BITS-1] == v)) begin
            res.run = {prev[RUN_BITS-1],
                       (prev[LEN_BITS-1:0] < LEN_CAP) ? prev[LEN_BITS-1:0] + 8'd1
                                                      : prev[LEN_BITS-1:0]};
        end else begin
            res.evt.old_run.vld = has_prev;
            res.evt.old_run.bin = run_bin(prev);
            res.run = {v, 8'd1};
        end
        res.evt.fin_run.vld = ends;
        res.evt.fin_run.bin = run_bin(res.run);
        return res;
    endfunction

endpackage

/* sv/binary_run_length_histogram.sv */
// Top level of the binary run-length histogram: scan position, pipeline and handshakes.
//
//  channel   dir  tdata / payload (lowest bit first)
//  s_axis    in   op[1:0], pixel_value[9:2], bin_select[16:10], zero to 24 bits
//  m_axis    out  bin_count[20:0], bin_echo[27:21], zero to 32 bits
//  cfg       in   index (0 image_width, 1 image_height), data[10:0]
//
// One beat is taken per cycle. A beat is registered at acceptance while the run
// memories are read, the run steps follow in the next cycle, and the counters are
// updated or read in the cycle after that; a read result is then written into the
// result queue, from whose head it is presented on the output.
// The input stalls only while the four-entry result queue, counting reads still in
// the pipeline, is full. Synchronous active-low reset clears counters and scan state.
module binary_run_length_histogram
    import brlh_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  logic [23:0]             i_s_axis_tdata,   // op, pixel_value, bin_select
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    output logic [31:0]             o_m_axis_tdata,   // bin_count, bin_echo
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [DIM_BITS-1:0]     i_cfg_data
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int QW = $clog2(FIFO_DEPTH + 1);
    localparam logic [CW-1:0] W_RESET = CW'((DIM_RESET < MAX_WIDTH) ? DIM_RESET : MAX_WIDTH);
    localparam logic [RW-1:0] H_RESET =
        RW'((DIM_RESET < MAX_HEIGHT) ? DIM_RESET : MAX_HEIGHT);
    localparam logic [AW-1:0] A_LAST = AW'(MAX_WIDTH - 1);

    // Scan position and effective dimensions.
    logic [CW-1:0] r_w, r_col;
    logic [RW-1:0] r_h, r_row;
    logic [AW-1:0] r_rm, r_di, r_ai;
    logic [AW-1:0] n_rm;
    logic [DIM_EXT_BITS-1:0] cfg_ext;
    logic [DIM_EXT_BITS-1:0] cfg_w, cfg_h;

    // Input decode.
    logic          acc;
    t_op           in_op;
    logic          in_v;
    logic          last_col, last_row;

    // Stage 1.
    logic                r_s1_vld;
    t_op                 r_s1_op;
    logic                r_s1_v;
    logic [SEL_BITS-1:0] r_s1_sel;
    logic [3:0]          r_s1_hp, r_s1_end;
    logic [AW-1:0]       r_s1_ca, r_s1_di, r_s1_ai;
    logic [RUN_BITS-1:0] r_row_run;
    t_run_res            row_res;
    t_evt_set            s1_evt;
    logic                s1_pix;

    // Stage 2.
    logic                r_s2_vld;
    t_op                 r_s2_op;
    logic [SEL_BITS-1:0] r_s2_sel;
    t_evt_set            r_s2_evt;

    logic                push;
    t_result             push_data, head;
    logic [QW-1:0]       q_count;
    logic [QW:0]         pending;

    assign in_op    = t_op'(i_s_axis_tdata[1:0]);
    assign in_v     = (i_s_axis_tdata[9:2] != 8'd0);
    assign pending  = (QW+1)'(q_count)
                    + (QW+1)'(r_s1_vld && r_s1_op == OP_READ)
                    + (QW+1)'(r_s2_vld && r_s2_op == OP_READ);
    assign o_s_axis_tready = (pending < (QW+1)'(FIFO_DEPTH));
    assign acc      = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready = 1'b1;

    assign last_col = ((CW+1)'(r_col) + 1'b1) >= (CW+1)'(r_w);
    assign last_row = ((RW+1)'(r_row) + 1'b1) >= (RW+1)'(r_h);
    assign n_rm     = (r_rm == A_LAST) ? '0 : r_rm + 1'b1;

    // Register values of zero act as one, values above the maximum as the maximum.
    assign cfg_ext = DIM_EXT_BITS'(i_cfg_data);
    assign cfg_w = (cfg_ext == '0) ? DIM_EXT_BITS'(1)
                 : (cfg_ext > DIM_EXT_BITS'(MAX_WIDTH)) ? DIM_EXT_BITS'(MAX_WIDTH) : cfg_ext;
    assign cfg_h = (cfg_ext == '0) ? DIM_EXT_BITS'(1)
                 : (cfg_ext > DIM_EXT_BITS'(MAX_HEIGHT)) ? DIM_EXT_BITS'(MAX_HEIGHT) : cfg_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w   <= W_RESET;
            r_h   <= H_RESET;
            r_col <= '0;
            r_row <= '0;
            r_rm  <= '0;
            r_di  <= '0;
            r_ai  <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_WIDTH)  r_w <= cfg_w[CW-1:0];
            if (i_cfg_index == REG_HEIGHT) r_h <= cfg_h[RW-1:0];
            if (i_cfg_index == REG_WIDTH || i_cfg_index == REG_HEIGHT) begin
                r_col <= '0;
                r_row <= '0;
                r_rm  <= '0;
                r_di  <= '0;
                r_ai  <= '0;
            end
        end else if (acc && in_op == OP_CLEAR) begin
            r_col <= '0;
            r_row <= '0;
            r_rm  <= '0;
            r_di  <= '0;
            r_ai  <= '0;
        end else if (acc && in_op == OP_PIXEL) begin
            if (!last_col) begin
                r_col <= r_col + 1'b1;
                r_di  <= (r_di == A_LAST) ? '0 : r_di + 1'b1;
                r_ai  <= (r_ai == A_LAST) ? '0 : r_ai + 1'b1;
            end else if (last_row) begin
                r_col <= '0;
                r_row <= '0;
                r_rm  <= '0;
                r_di  <= '0;
                r_ai  <= '0;
            end else begin
                // New row: the diagonal slot is minus the row, the anti-diagonal slot the row.
                r_col <= '0;
                r_row <= r_row + 1'b1;
                r_rm  <= n_rm;
                r_di  <= (n_rm == '0) ? '0 : AW'(MAX_WIDTH) - n_rm;
                r_ai  <= n_rm;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= acc;
            r_s2_vld <= r_s1_vld;
        end
        r_s1_op  <= in_op;
        r_s1_v   <= in_v;
        r_s1_sel <= i_s_axis_tdata[16:10];
        r_s1_ca  <= r_col[AW-1:0];
        r_s1_di  <= r_di;
        r_s1_ai  <= r_ai;
        r_s1_hp  <= {(r_row != '0) && !last_col, (r_row != '0) && (r_col != '0),
                     (r_row != '0), (r_col != '0)};
        r_s1_end <= {last_row || (r_col == '0), last_row || last_col, last_row, last_col};
        r_s2_op  <= r_s1_op;
        r_s2_sel <= r_s1_sel;
        r_s2_evt <= s1_evt;
    end

    assign s1_pix  = r_s1_vld && (r_s1_op == OP_PIXEL);
    assign row_res = run_step(r_row_run, r_s1_hp[0], r_s1_v, r_s1_end[0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_run <= '0;
        end else if (r_s1_vld && r_s1_op == OP_CLEAR) begin
            r_row_run <= '0;
        end else if (s1_pix) begin
            r_row_run <= row_res.run;
        end
    end

    t_dir_evt col_evt, dia_evt, ant_evt;

    brlh_dir #(.MAX_WIDTH(MAX_WIDTH)) u_col (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_re (acc && in_op == OP_PIXEL), .i_raddr (r_col[AW-1:0]),
        .i_s1_pix (s1_pix), .i_s1_addr (r_s1_ca), .i_v (r_s1_v),
        .i_has_prev (r_s1_hp[1]), .i_ends (r_s1_end[1]), .o_evt (col_evt)
    );

    brlh_dir #(.MAX_WIDTH(MAX_WIDTH)) u_dia (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_re (acc && in_op == OP_PIXEL), .i_raddr (r_di),
        .i_s1_pix (s1_pix), .i_s1_addr (r_s1_di), .i_v (r_s1_v),
        .i_has_prev (r_s1_hp[2]), .i_ends (r_s1_end[2]), .o_evt (dia_evt)
    );

    brlh_dir #(.MAX_WIDTH(MAX_WIDTH)) u_ant (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_re (acc && in_op == OP_PIXEL), .i_raddr (r_ai),
        .i_s1_pix (s1_pix), .i_s1_addr (r_s1_ai), .i_v (r_s1_v),
        .i_has_prev (r_s1_hp[3]), .i_ends (r_s1_end[3]), .o_evt (ant_evt)
    );

    always_comb begin
        s1_evt = '0;
        if (s1_pix) begin
            s1_evt[0] = row_res.evt;
            s1_evt[1] = col_evt;
            s1_evt[2] = dia_evt;
            s1_evt[3] = ant_evt;
        end
    end

    brlh_hist #(.COUNT_BITS(COUNT_BITS)) u_hist (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_vld (r_s2_vld), .i_op (r_s2_op), .i_evt (r_s2_evt), .i_sel (r_s2_sel),
        .o_push (push), .o_result (push_data)
    );

    brlh_fifo u_fifo (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_push (push), .i_data (push_data),
        .i_pop (i_m_axis_tready), .o_vld (o_m_axis_tvalid),
        .o_data (head), .o_count (q_count)
    );

    assign o_m_axis_tdata = {4'd0, head.echo, head.count};

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= QW'(FIFO_DEPTH))
        else $error("result queue count beyond its depth");

    a_read_reaches_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && in_op == OP_READ) |=> ##1 push)
        else $error("accepted read beat did not reach the result queue");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && q_count == QW'(FIFO_DEPTH)) |-> i_m_axis_tready)
        else $error("read result pushed into a full queue");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col < r_w) && (r_row < r_h))
        else $error("scan position outside the region");
`endif
endmodule

/* sv/brlh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module brlh_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) r_rdata <= r_mem[i_raddr];
        if (i_we) r_mem[i_waddr] <= i_wdata;
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/brlh_dir.sv */
// Run tracker for one stored direction: run memory, write-back bypass and run step.
module brlh_dir
    import brlh_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_re,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_raddr,
    input  logic                         i_s1_pix,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_s1_addr,
    input  logic                         i_v,
    input  logic                         i_has_prev,
    input  logic                         i_ends,
    output t_dir_evt                     o_evt
);
    localparam int AW = $clog2(MAX_WIDTH);

    logic [RUN_BITS-1:0] ram_rdata;
    logic [RUN_BITS-1:0] prev;
    logic                r_wr_vld;
    logic [AW-1:0]       r_wr_addr;
    logic [RUN_BITS-1:0] r_wr_data;
    t_run_res            res;

    brlh_ram #(.WIDTH(RUN_BITS), .DEPTH(MAX_WIDTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_s1_pix),
        .i_waddr (i_s1_addr),
        .i_wdata (res.run),
        .i_re    (i_re),
        .i_raddr (i_raddr),
        .o_rdata (ram_rdata)
    );

    // A write landing on the same edge as this beat's read is not seen in the RAM read data.
    assign prev = (r_wr_vld && (r_wr_addr == i_s1_addr)) ? r_wr_data : ram_rdata;
    assign res  = run_step(prev, i_has_prev, i_v, i_ends);
    assign o_evt = res.evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_vld <= 1'b0;
        end else begin
            r_wr_vld <= i_s1_pix;
        end
        r_wr_addr <= i_s1_addr;
        r_wr_data <= res.run;
    end
endmodule

/* sv/brlh_hist.sv */
// Bank of 72 saturating run counters with clear, update and counter read.
module brlh_hist
    import brlh_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  t_op                 i_op,
    input  t_evt_set            i_evt,
    input  logic [SEL_BITS-1:0] i_sel,
    output logic                o_push,
    output t_result             o_result
);
    localparam logic [COUNT_BITS:0] CNT_MAX = {1'b0, {COUNT_BITS{1'b1}}};

    logic [COUNT_BITS-1:0] r_hist [NUM_BINS];
    logic [COUNT_BITS-1:0] n_hist [NUM_BINS];
    logic [31:0]           sel_count;

    always_comb begin
        for (int k = 0; k < NUM_BINS; k++) begin
            logic [COUNT_BITS:0] sum;
            sum = {1'b0, r_hist[k]}
                + (COUNT_BITS+1)'(i_evt[k / BINS_PER_DIR].old_run.vld
                    && i_evt[k / BINS_PER_DIR].old_run.bin == BIN_BITS'(k % BINS_PER_DIR))
                + (COUNT_BITS+1)'(i_evt[k / BINS_PER_DIR].fin_run.vld
                    && i_evt[k / BINS_PER_DIR].fin_run.bin == BIN_BITS'(k % BINS_PER_DIR));
            n_hist[k] = r_hist[k];
            if (i_vld && i_op == OP_CLEAR) begin
                n_hist[k] = '0;
            end else if (i_vld && i_op == OP_PIXEL) begin
                n_hist[k] = (sum > CNT_MAX) ? CNT_MAX[COUNT_BITS-1:0] : sum[COUNT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_BINS; k++) r_hist[k] <= '0;
        end else begin
            for (int k = 0; k < NUM_BINS; k++) r_hist[k] <= n_hist[k];
        end
    end

    // Selects beyond the last counter read as zero.
    assign sel_count = (i_sel < SEL_BITS'(NUM_BINS)) ? 32'(r_hist[i_sel]) : 32'd0;
    assign o_push         = i_vld && (i_op == OP_READ);
    assign o_result.echo  = i_sel;
    assign o_result.count = sel_count[OUT_CNT_BITS-1:0];
endmodule

/* sv/brlh_fifo.sv */
// Small result queue that decouples counter reads from the output stream.
module brlh_fifo
    import brlh_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    input  logic    i_pop,
    output logic    o_vld,
    output t_result o_data,
    output logic [$clog2(FIFO_DEPTH+1)-1:0] o_count
);
    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH+1);

    t_result       r_mem [FIFO_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          pop;

    assign o_vld  = (r_count != '0);
    assign pop    = i_pop && o_vld;
    assign o_data = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop)    r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + CW'(i_push) - CW'(pop);
        end
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end
endmodule

/* dv/binary_run_length_histogram_test.sv */
// Self-checking testbench for the binary run-length histogram: directed and random frames.
module binary_run_length_histogram_test;
    import brlh_pkg::*;

    localparam int MAXW = 1024;
    localparam int CNT_MAX = (1 << 21) - 1;
    localparam int WATCHDOG_LIMIT = 20000;

    // Predicts counter reads from pixel beats and checks returned counts in order.
    class histogram_scoreboard;
        int unsigned hist[NUM_BINS];
        logic [8:0] row_run_q;
        logic [8:0] col_runs[MAXW];
        logic [8:0] diag_runs[MAXW];
        logic [8:0] anti_runs[MAXW];
        int unsigned width_reg, height_reg, scan_r, scan_c;
        logic [27:0] pending_reads[$];
        int errors, reads_checked, pixels_seen;

        function void clear_all();
            foreach (hist[i]) hist[i] = 0;
            row_run_q = '0;
            scan_r = 0;
            scan_c = 0;
        endfunction

        function void set_dimension(logic [CFG_IDX_BITS-1:0] idx, logic [DIM_BITS-1:0] val);
            if (idx == REG_WIDTH) width_reg = val;
            else if (idx == REG_HEIGHT) height_reg = val;
            else return;
            scan_r = 0;
            scan_c = 0;
        endfunction

        function int unsigned bin_of(int dir, logic [8:0] run);
            int unsigned len, cls;
            len = run[7:0];
            cls = 0;
            if (len > 128) cls = 8;
            else while (len > 1 && (1 << cls) < len) cls++;
            return dir * 18 + (run[8] ? 9 : 0) + cls;
        endfunction

        function void bump(int dir, logic [8:0] run);
            int unsigned b;
            b = bin_of(dir, run);
            if (hist[b] < CNT_MAX) hist[b]++;
        endfunction

        function logic [8:0] run_advance(int dir, logic [8:0] prev, bit has_prev, bit v,
                                         bit ends);
            logic [8:0] nxt;
            if (has_prev && prev[8] == v) begin
                nxt = prev;
                if (prev[7:0] < 129) nxt[7:0] = prev[7:0] + 1;
            end else begin
                if (has_prev) bump(dir, prev);
                nxt = {v, 8'd1};
            end
            if (ends) bump(dir, nxt);
            return nxt;
        endfunction

        // Notes one accepted input beat.
        function void note_input(logic [23:0] beat);
            t_op op;
            int unsigned w, h, r, c, di, ai, sel;
            bit v, lc, lr;
            op = t_op'(beat[1:0]);
            case (op)
                OP_CLEAR: clear_all();
                OP_READ: begin
                    sel = beat[16:10];
                    pending_reads.push_back({beat[16:10],
                        21'(sel < NUM_BINS ? hist[sel] : 0)});
                end
                OP_PIXEL: begin
                    pixels_seen++;
                    w = width_reg == 0 ? 1 : (width_reg > MAXW ? MAXW : width_reg);
                    h = height_reg == 0 ? 1 : (height_reg > 1024 ? 1024 : height_reg);
                    r = scan_r;
                    c = scan_c;
                    v = beat[9:2] != 0;
                    lc = c + 1 >= w;
                    lr = r + 1 >= h;
                    di = (c + MAXW - r) % MAXW;
                    ai = (c + r) % MAXW;
                    row_run_q = run_advance(0, row_run_q, c > 0, v, lc);
                    col_runs[c] = run_advance(1, col_runs[c], r > 0, v, lr);
                    diag_runs[di] = run_advance(2, diag_runs[di], r > 0 && c > 0, v, lr || lc);
                    anti_runs[ai] = run_advance(3, anti_runs[ai], r > 0 && !lc, v,
                                                lr || c == 0);
                    c++;
                    if (c >= w) begin
                        c = 0;
                        r++;
                        if (r >= h) r = 0;
                    end
                    scan_r = r;
                    scan_c = c;
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [31:0] data);
            logic [27:0] exp_v;
            if (data[31:28] != 0) begin
                errors++;
                if (errors <= 10) $display("padding bits nonzero: %h", data);
            end
            if (pending_reads.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %h", data);
                return;
            end
            exp_v = pending_reads.pop_front();
            reads_checked++;
            if (data[20:0] != exp_v[20:0] || data[27:21] != exp_v[27:21]) begin
                errors++;
                if (errors <= 10)
                    $display("bin %0d: expected count %0d echo %0d, got count %0d echo %0d",
                             exp_v[27:21], exp_v[20:0], exp_v[27:21], data[20:0], data[27:21]);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic i_s_axis_tvalid, o_s_axis_tready, o_m_axis_tvalid, i_m_axis_tready;
    logic [23:0] i_s_axis_tdata;
    logic [31:0] o_m_axis_tdata;
    logic i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index;
    logic [DIM_BITS-1:0] i_cfg_data;

    histogram_scoreboard hist_sb;
    bit idle_allowed;
    int stall_cycles = 0;

    binary_run_length_histogram DUT (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Counts stalled cycles and fails the test when they reach the watchdog limit.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else if (i_rst_n) begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("binary_run_length_histogram test failed");
                $finish;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) hist_sb.check_result(o_m_axis_tdata);
    end

    // Result-side stalls in random bursts.
    initial begin
        int gap;
        i_m_axis_tready = 1;
        forever begin
            @(posedge i_clk);
            if (idle_allowed && $urandom_range(0, 9) == 0) begin
                gap = $urandom_range(1, 7);
                i_m_axis_tready <= 0;
                repeat (gap) @(posedge i_clk);
                i_m_axis_tready <= 1;
            end
        end
    end

    // Valid stays high after a beat so that beats follow back to back; it is dropped
    // by an idle burst or when the sender waits.
    task automatic send_beat(t_op op, logic [7:0] pix, logic [6:0] sel);
        int gap;
        if (idle_allowed && $urandom_range(0, 11) == 0) begin
            gap = $urandom_range(1, 7);
            i_s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1;
        i_s_axis_tdata <= {7'd0, sel, pix, op};
        do @(posedge i_clk); while (!o_s_axis_tready);
        hist_sb.note_input({7'd0, sel, pix, op});
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 0;
        while (hist_sb.pending_reads.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_dimension(logic [CFG_IDX_BITS-1:0] idx, logic [DIM_BITS-1:0] val);
        wait_drained();
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        hist_sb.set_dimension(idx, val);
        i_cfg_valid <= 0;
    endtask

    task automatic read_all_bins();
        for (int b = 0; b < NUM_BINS; b++) send_beat(OP_READ, 8'($urandom), 7'(b));
    endtask

    // A frame of w x h pixels, mostly in runs so that long runs occur, then a few reads.
    task automatic random_frame(int w, int h);
        bit v;
        v = $urandom_range(0, 1);
        write_dimension(REG_WIDTH, DIM_BITS'(w));
        write_dimension(REG_HEIGHT, DIM_BITS'(h));
        if ($urandom_range(0, 2) != 0) send_beat(OP_CLEAR, 8'($urandom), 7'($urandom));
        for (int i = 0; i < w * h; i++) begin
            if ($urandom_range(0, 5) == 0) v = !v;
            send_beat(OP_PIXEL, v ? 8'($urandom_range(1, 255)) : 8'd0, 7'($urandom));
            if ($urandom_range(0, 15) == 0)
                send_beat($urandom_range(0, 1) ? OP_READ : OP_NONE, 8'($urandom),
                          7'($urandom));
        end
        repeat ($urandom_range(2, 6)) send_beat(OP_READ, 8'($urandom),
                                                7'($urandom_range(0, 79)));
    endtask

    initial begin
        int w, h;
        hist_sb = new();
        hist_sb.width_reg = DIM_RESET;
        hist_sb.height_reg = DIM_RESET;
        hist_sb.clear_all();
        idle_allowed = 0;
        i_rst_n = 0;
        i_s_axis_tvalid = 0;
        i_s_axis_tdata = '0;
        i_cfg_valid = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: 130-pixel single row gives a capped run, extreme reads and op 3.
        write_dimension(REG_WIDTH, 11'd130);
        write_dimension(REG_HEIGHT, 11'd1);
        for (int i = 0; i < 130; i++) send_beat(OP_PIXEL, 8'hFF, 7'd0);
        send_beat(OP_READ, 8'd0, 7'd8 + 7'd9);
        send_beat(OP_READ, 8'd0, 7'd71);
        send_beat(OP_READ, 8'd0, 7'd127);
        send_beat(OP_NONE, 8'hFF, 7'd5);
        // Out-of-range dimensions: zero acts as one, oversized acts as maximum.
        write_dimension(REG_WIDTH, 11'd0);
        write_dimension(REG_HEIGHT, 11'h7FF);
        for (int i = 0; i < 6; i++) send_beat(OP_PIXEL, 8'(i & 1), 7'd0);
        write_dimension(REG_HEIGHT, 11'd0);
        send_beat(OP_PIXEL, 8'h80, 7'h7F);
        send_beat(OP_PIXEL, 8'h01, 7'h40);
        send_beat(OP_CLEAR, 8'hFF, 7'h7F);
        read_all_bins();

        idle_allowed = 1;
        for (int f = 0; f < 60; f++) begin
            w = $urandom_range(0, 9) == 0 ? $urandom_range(1, 40) : $urandom_range(1, 5);
            h = $urandom_range(1, 5);
            if (f == 30) wait_drained();
            random_frame(w, h);
        end
        write_dimension(REG_WIDTH, 11'd1024);
        write_dimension(REG_HEIGHT, 11'd1);
        for (int i = 0; i < 300; i++) send_beat(OP_PIXEL, 8'($urandom_range(0, 1)), 7'd0);
        idle_allowed = 0;
        read_all_bins();

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d pixel beats and %0d checked counter reads",
                 hist_sb.pixels_seen, hist_sb.reads_checked);
        $display("over directed edge cases and %0d random small frames.", 60);
        if (hist_sb.errors == 0 && hist_sb.pending_reads.size() == 0)
            $display("binary_run_length_histogram test passed");
        else
            $display("binary_run_length_histogram test failed");
        $finish;
    end
endmodule
